// File: rtl/core/quantized_key_match_join_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef QUANTIZED_KEY_MATCH_JOIN_MACROS_SVH
`define QUANTIZED_KEY_MATCH_JOIN_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define QKMJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define QKMJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/qkmj_pkg.sv
package qkmj_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int CMD_W   = 2;
	localparam int MASS_W  = 28;
	localparam int INT_W   = 32;
	localparam int TAG_W   = 16;
	localparam int KEY_W   = 22;
	localparam int RIDX_W  = 6;
	localparam int MODE_W  = 2;

	// Offset mass (mass plus the rounding half) and the constant divisor.
	localparam int DIV_W     = MASS_W + 1;
	localparam int DIVISOR   = 100;
	localparam int HALF      = 50;

	// Divide by 100 as a quarter of the dividend times ceil(2^32 / 25), high bits kept.
	// Exact for every quarter below 2^30.
	localparam int QTR_W       = DIV_W - 2;
	localparam int RECIP_W     = 28;
	localparam int RECIP_MUL   = 171798692;
	localparam int RECIP_SHIFT = 32;
	localparam int PROD_W      = QTR_W + RECIP_W;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 104;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_BOUND = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	// Control of the cell row.
	typedef struct packed {
		logic shift;
		logic load;
	} row_ctl_t;

endpackage

// File: rtl/core/quantized_key_match_join.sv
// Load, clear and unused-code beats leave the block idle; s_tready stays high while idle.
// A query beat holds s_tready low while it reduces its key (reciprocal multiply by
// 1/100), forms the match window, rotates the whole entry ring past the head compare
// and takes a flush step, longer when m_tready stalls, and only then takes a new beat.
// Reset clears control state and the entry count; table contents stay undefined.
`include "quantized_key_match_join_macros.svh"

module quantized_key_match_join
	import qkmj_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: pair_mode
	input  logic                 cfg_we,
	input  logic [MODE_W-1:0]    cfg_data,
	// input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // mass_value[27:0], peak_intensity[59:28],
	                                        // query_tag[75:60], zero pad
	input  logic [CMD_W-1:0]     s_tuser,   // cmd[1:0]
	// result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // match_tag[15:0], ref_index[21:16],
	                                        // common_key[43:22], ref_mass[71:44],
	                                        // ref_intensity[103:72]
	output logic                 m_tlast    // last_match
);

	// Input beat fields.
	logic [MASS_W-1:0] in_mass;
	logic [INT_W-1:0]  in_int;
	logic [TAG_W-1:0]  in_tag;
	logic              in_fire;

	assign in_mass = s_tdata[MASS_W-1:0];
	assign in_int  = s_tdata[MASS_W+INT_W-1:MASS_W];
	assign in_tag  = s_tdata[MASS_W+INT_W+TAG_W-1:MASS_W+INT_W];

	state_t            state_q;
	logic [MODE_W-1:0] pair_mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [TAG_W-1:0]  tag_q;
	logic [KEY_W-1:0]  key_q;
	logic [DIV_W-1:0]  lo_q;
	logic [DIV_W-1:0]  hi_q;
	logic [IDX_W-1:0]  idx_q;

	// A match is held back one step so the last one can be flagged.
	logic              pend_v_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [MASS_W-1:0] pend_mass_q;
	logic [INT_W-1:0]  pend_int_q;

	// Output register.
	logic              out_v_q;
	logic              out_last_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [MASS_W-1:0] out_mass_q;
	logic [INT_W-1:0]  out_int_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [KEY_W-1:0]  out_key_q;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// Query key: divide the (optionally half-offset) query mass by 100.
	logic             div_start;
	logic             div_done;
	logic [KEY_W-1:0] div_quot;
	logic [DIV_W-1:0] div_x;

	assign div_start = in_fire && (s_tuser == CMD_QUERY);
	assign div_x     = {1'b0, in_mass} + (pair_mode_q[1] ? DIV_W'(0) : DIV_W'(HALF));

	qkmj_keydiv u_keydiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.x      (div_x),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Match window on the offset reference mass: 100*key .. 100*key + 99.
	logic [DIV_W-1:0] lo_calc;
	assign lo_calc = (DIV_W'(key_q) << 6) + (DIV_W'(key_q) << 5) + (DIV_W'(key_q) << 2);

	// Entry ring: cell i takes from cell i+1, cell 0 is the compare head.
	logic [MASS_W-1:0] cell_mass [TABLE_DEPTH];
	logic [INT_W-1:0]  cell_int  [TABLE_DEPTH];
	logic              load_fire;
	logic              advance;

	assign load_fire = in_fire && (s_tuser == CMD_LOAD) && (count_q < CNT_W'(TABLE_DEPTH));

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % TABLE_DEPTH;
		row_ctl_t ctl;
		assign ctl.load  = load_fire && (count_q == CNT_W'(i));
		assign ctl.shift = advance;
		qkmj_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load_mass (in_mass),
			.load_int  (in_int),
			.nxt_mass  (cell_mass[NXT]),
			.nxt_int   (cell_int[NXT]),
			.mass      (cell_mass[i]),
			.inten     (cell_int[i])
		);
	end

	// Head compare.
	logic [DIV_W-1:0] head_off;
	logic             head_match;
	logic             slot_free;
	logic             scan_end;
	logic             out_load;

	assign head_off   = {1'b0, cell_mass[0]} + (pair_mode_q[0] ? DIV_W'(0) : DIV_W'(HALF));
	assign head_match = (CNT_W'(idx_q) < count_q) && (head_off >= lo_q) && (head_off <= hi_q);
	assign slot_free  = !out_v_q || m_tready;
	// Stall only when a new match must push the held one into a full output.
	assign advance    = (state_q == ST_SCAN) && !(head_match && pend_v_q && !slot_free);
	assign scan_end   = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	// Move the held match to the output on a new match or at the flush.
	assign out_load   = (advance && head_match && pend_v_q) ||
		(state_q == ST_FLUSH && pend_v_q && slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pair_mode_q <= '0;
			count_q     <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				pair_mode_q <= cfg_data;
			end
			out_v_q <= out_load || (out_v_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (s_tuser)
							CMD_CLEAR: count_q <= '0;
							CMD_LOAD: begin
								if (load_fire) begin
									count_q <= count_q + 1'b1;
								end
							end
							CMD_QUERY: state_q <= ST_DIV;
							default: ; // drop unused command code
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BOUND;
					end
				end
				ST_BOUND: begin
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (advance) begin
						if (head_match) begin
							pend_v_q <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (div_start) begin
			tag_q <= in_tag;
		end
		if (div_done) begin
			key_q <= div_quot;
		end
		if (state_q == ST_BOUND) begin
			lo_q <= lo_calc;
			hi_q <= lo_calc + DIV_W'(DIVISOR - 1);
		end
		if (advance && head_match) begin
			pend_idx_q  <= idx_q;
			pend_mass_q <= cell_mass[0];
			pend_int_q  <= cell_int[0];
		end
		if (out_load) begin
			out_idx_q  <= pend_idx_q;
			out_mass_q <= pend_mass_q;
			out_int_q  <= pend_int_q;
			out_tag_q  <= tag_q;
			out_key_q  <= key_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_int_q, out_mass_q, out_key_q, RIDX_W'(out_idx_q), out_tag_q};

	`QKMJ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "entry count over depth")
	`QKMJ_ASSERT_NOW(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "held match left in idle")
	`QKMJ_ASSERT_NOW(a_div_in_div, div_done, state_q == ST_DIV, "divide done outside divide")
	`QKMJ_ASSERT_NEXT(a_scan_to_flush, advance && scan_end, state_q == ST_FLUSH, "scan overran")

endmodule

// File: rtl/core/qkmj_cell.sv
// One table entry. Load from the write port, or take the neighbor's entry.
module qkmj_cell
	import qkmj_pkg::*;
(
	input  logic              clk,
	input  row_ctl_t          ctl,
	input  logic [MASS_W-1:0] load_mass,
	input  logic [INT_W-1:0]  load_int,
	input  logic [MASS_W-1:0] nxt_mass,
	input  logic [INT_W-1:0]  nxt_int,
	output logic [MASS_W-1:0] mass,
	output logic [INT_W-1:0]  inten
);

	logic [MASS_W-1:0] mass_q;
	logic [INT_W-1:0]  int_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mass_q <= load_mass;
			int_q  <= load_int;
		end else if (ctl.shift) begin
			mass_q <= nxt_mass;
			int_q  <= nxt_int;
		end
	end

	assign mass  = mass_q;
	assign inten = int_q;

endmodule

// File: rtl/core/qkmj_keydiv.sv
// Division by the constant divisor: quarter the dividend, multiply by the
// scaled reciprocal of 25 and keep the high bits. The quarter and then the product are registered.
module qkmj_keydiv
	import qkmj_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] x,
	output logic             done,
	output logic [KEY_W-1:0] quot
);

	logic              start_s1;
	logic              done_s2;
	logic [QTR_W-1:0]  qtr_s1;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			start_s1 <= start;
			done_s2  <= start_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qtr_s1 <= x[DIV_W-1:2];
		end
		if (start_s1) begin
			prod_s2 <= PROD_W'(qtr_s1) * PROD_W'(RECIP_MUL);
		end
	end

	assign done = done_s2;
	assign quot = prod_s2[RECIP_SHIFT +: KEY_W];

endmodule

// File: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import qkmj_pkg::*;

	// cmd code that the block has no operation for
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// pair_mode values: bit 1 truncates the query key, bit 0 the stored key
	localparam logic [MODE_W-1:0] MODE_ROUND_ROUND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ROUND_TRUNC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRUNC_ROUND = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRUNC_TRUNC = 2'd3;

	localparam logic [MASS_W-1:0] MASS_MAX = '1;
	localparam longint            MASS_TOP = 268435455;

	// A query keeps the block busy even with a free output; the receiver holds off
	// for at most HOLD_CYCLES, senders gap between beats at random. Several times the
	// longest quiet stretch of a correct run.
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 600;
	localparam int RANDOM_ITEMS = 264;
	localparam int RANDOM_PHASES = 6;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [RIDX_W-1:0] idx;
		logic [KEY_W-1:0]  key;
		logic [MASS_W-1:0] mass;
		logic [INT_W-1:0]  inten;
		logic              last;
	} match_beat_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [MODE_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [CMD_W-1:0]     s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	// Our own image of the peak table and the key mode.
	logic [MASS_W-1:0] peak_mass  [TABLE_DEPTH];
	logic [INT_W-1:0]  peak_inten [TABLE_DEPTH];
	int unsigned       peak_count = 0;
	logic [MODE_W-1:0] key_mode   = MODE_ROUND_ROUND;
	match_beat_t       pending_matches[$];

	int unsigned items_accepted  = 0;
	int unsigned matches_checked = 0;
	int unsigned mismatches      = 0;
	int unsigned idle_cycles     = 0;
	int unsigned rx_hold         = 0;
	bit          tx_idle_on      = 1'b1;
	bit          rx_idle_on      = 1'b1;
	bit [3:0]    modes_seen      = '0;

	quantized_key_match_join u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reduce a mass in 1e-4 units to hundredths: round half up or truncate.
	function automatic logic [KEY_W-1:0] hundredths_key(input logic [MASS_W-1:0] mass,
			input bit trunc);
		logic [MASS_W:0] biased;
		biased = {1'b0, mass};
		if (!trunc)
			biased = biased + 29'd50;
		return KEY_W'(biased / 29'd100);
	endfunction

	// Any tag value.
	function automatic logic [TAG_W-1:0] random_tag();
		return TAG_W'($urandom);
	endfunction

	// Mostly uniform over all 28 bits, now and then hugging either end.
	function automatic logic [MASS_W-1:0] random_mass();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return MASS_W'($urandom_range(0, 200));
		if (pick == 1)
			return MASS_MAX - MASS_W'($urandom_range(0, 200));
		return MASS_W'($urandom);
	endfunction

	// A mass within a key or so of centre, so that keys collide often.
	function automatic logic [MASS_W-1:0] near_mass(input logic [MASS_W-1:0] centre);
		longint m;
		int     off;
		off = int'($urandom_range(0, 160)) - 80;
		m = longint'(centre) + off;
		if (m < 0)
			m = 0;
		if (m > MASS_TOP)
			m = MASS_TOP;
		return MASS_W'(m);
	endfunction

	// Apply one accepted beat to the table image and queue the matches it causes.
	task automatic absorb_item(input logic [CMD_W-1:0] cmd, input logic [MASS_W-1:0] mass,
			input logic [INT_W-1:0] inten, input logic [TAG_W-1:0] tag);
		logic [KEY_W-1:0] qkey;
		match_beat_t      beat;
		int               i;
		int               last_hit;
		case (cmd)
			CMD_CLEAR: begin
				peak_count = 0;
			end
			CMD_LOAD: begin
				// a full table drops the load
				if (peak_count < TABLE_DEPTH) begin
					peak_mass[peak_count]  = mass;
					peak_inten[peak_count] = inten;
					peak_count++;
				end
			end
			CMD_QUERY: begin
				qkey = hundredths_key(mass, key_mode[1]);
				last_hit = -1;
				for (i = 0; i < peak_count; i++)
					if (hundredths_key(peak_mass[i], key_mode[0]) == qkey)
						last_hit = i;
				for (i = 0; i < peak_count; i++) begin
					if (hundredths_key(peak_mass[i], key_mode[0]) == qkey) begin
						beat.tag   = tag;
						beat.idx   = RIDX_W'(i);
						beat.key   = qkey;
						beat.mass  = peak_mass[i];
						beat.inten = peak_inten[i];
						beat.last  = (i == last_hit);
						pending_matches.insert(pending_matches.size(), beat);
					end
				end
			end
			default: begin
				// unused code: no effect
			end
		endcase
	endtask

	// Offer one beat after a random gap and hold it until accepted.
	// Entered and left at a rising edge; valid stays high into the next item.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [MASS_W-1:0] mass,
			input logic [INT_W-1:0] inten, input logic [TAG_W-1:0] tag);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, tag, inten, mass};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_item(cmd, mass, inten, tag);
		if (cmd != CMD_UNUSED)
			items_accepted++;
	endtask

	// Drop valid, wait for every match, then let a zero-match scan run out.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_matches.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pair_mode(input logic [MODE_W-1:0] mode);
		cfg_we   <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we   <= 1'b0;
		key_mode = mode;
		modes_seen[mode] = 1'b1;
	endtask

	task automatic report_fault(input string why, input match_beat_t want,
			input match_beat_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%s at %0t: want tag %h idx %0d key %0d mass %0d int %h last %b",
				why, $realtime, want.tag, want.idx, want.key, want.mass, want.inten, want.last);
			$display("    got tag %h idx %0d key %0d mass %0d int %h last %b",
				got.tag, got.idx, got.key, got.mass, got.inten, got.last);
		end
	endtask

	// Rounding boundaries in round/round mode, both ends of every field,
	// a query on the empty table, a miss and the unused code.
	task automatic test_rounding_edges();
		write_pair_mode(MODE_ROUND_ROUND);
		send_item(CMD_QUERY, 28'd5000, 32'd0, 16'h1234);
		send_item(CMD_LOAD, 28'd0, 32'd0, 16'h0000);
		send_item(CMD_LOAD, 28'd49, $urandom, random_tag());
		send_item(CMD_LOAD, 28'd50, $urandom, random_tag());
		send_item(CMD_LOAD, 28'd149, $urandom, random_tag());
		send_item(CMD_LOAD, 28'd150, $urandom, random_tag());
		send_item(CMD_LOAD, MASS_MAX, '1, 16'hffff);
		send_item(CMD_QUERY, 28'd0, '1, 16'h0000);
		send_item(CMD_QUERY, 28'd50, 32'd0, 16'hffff);
		send_item(CMD_QUERY, 28'd150, $urandom, random_tag());
		send_item(CMD_QUERY, MASS_MAX, $urandom, random_tag());
		send_item(CMD_QUERY, 28'd77777700, $urandom, random_tag());
		send_item(CMD_UNUSED, MASS_MAX, '1, 16'hffff);
		drain_block();
	endtask

	// Same table under the other three modes, then a query after a clear.
	task automatic test_pair_modes();
		logic [MODE_W-1:0] mode;
		for (int m = 1; m < 4; m++) begin
			mode = MODE_W'(m);
			write_pair_mode(mode);
			send_item(CMD_QUERY, 28'd49, $urandom, random_tag());
			send_item(CMD_QUERY, 28'd149, $urandom, random_tag());
			send_item(CMD_QUERY, 28'd150, $urandom, random_tag());
			send_item(CMD_QUERY, MASS_MAX, $urandom, random_tag());
			drain_block();
		end
		send_item(CMD_CLEAR, random_mass(), $urandom, random_tag());
		send_item(CMD_QUERY, 28'd150, $urandom, random_tag());
		drain_block();
	endtask

	// Fill past the depth with one key: extra loads drop, a query hits all 64.
	task automatic test_table_full();
		write_pair_mode(MODE_ROUND_ROUND);
		send_item(CMD_CLEAR, 28'd0, 32'd0, 16'd0);
		repeat (TABLE_DEPTH + 2)
			send_item(CMD_LOAD, 28'd1000000 + MASS_W'($urandom_range(0, 49)), $urandom,
				random_tag());
		send_item(CMD_QUERY, 28'd1000020, $urandom, random_tag());
		drain_block();
	endtask

	// Hold the receiver off while queries keep coming, so the block backs up
	// and stalls its input.
	task automatic test_output_stall();
		send_item(CMD_CLEAR, 28'd0, 32'd0, 16'd0);
		repeat (32)
			send_item(CMD_LOAD, 28'd2000000 + MASS_W'($urandom_range(0, 40)), $urandom,
				random_tag());
		tx_idle_on = 1'b0;
		rx_hold = HOLD_CYCLES;
		repeat (6)
			send_item(CMD_QUERY, 28'd2000010, $urandom, random_tag());
		drain_block();
		tx_idle_on = 1'b1;
	endtask

	// Mostly loads clustered around a moving centre and queries aimed at stored
	// peaks, with clears, misses and unused codes mixed in; a mode set per phase.
	task automatic test_random_traffic();
		int unsigned       target;
		int unsigned       pick;
		int unsigned       burst;
		logic [MASS_W-1:0] centre;
		logic [MASS_W-1:0] qmass;
		logic [MODE_W-1:0] mode;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       mode = MODE_TRUNC_TRUNC;
				1:       mode = MODE_ROUND_TRUNC;
				2:       mode = MODE_TRUNC_ROUND;
				3:       mode = MODE_ROUND_ROUND;
				default: mode = MODE_W'($urandom_range(0, 3));
			endcase
			write_pair_mode(mode);
			// phase 2 runs flat out on both sides
			tx_idle_on = (phase != 2) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (phase != 2) && ($urandom_range(0, 3) != 0);
			centre = random_mass();
			target = items_accepted + RANDOM_ITEMS / RANDOM_PHASES;
			while (items_accepted < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send_item(CMD_CLEAR, random_mass(), $urandom, random_tag());
				end else if (pick < 9) begin
					send_item(CMD_UNUSED, random_mass(), $urandom, random_tag());
				end else if (pick < 40) begin
					burst = $urandom_range(1, 6);
					repeat (burst)
						send_item(CMD_LOAD, (pick < 33) ? near_mass(centre) : random_mass(),
							$urandom, random_tag());
				end else begin
					pick = $urandom_range(0, 99);
					if (peak_count > 0 && pick < 70)
						qmass = near_mass(peak_mass[$urandom_range(0, peak_count - 1)]);
					else if (pick < 85)
						qmass = near_mass(centre);
					else
						qmass = random_mass();
					send_item(CMD_QUERY, qmass, $urandom, random_tag());
				end
				if ($urandom_range(0, 19) == 0)
					centre = random_mass();
			end
			drain_block();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver: draw a stall per beat, or serve a long hold-off when asked.
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				stall = rx_idle_on ? $urandom_range(0, 7) : 0;
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
				while (!m_tvalid && rx_hold == 0) @(posedge clk);
			end
		end
	end

	// Check every accepted result beat against the oldest queued match.
	always @(posedge clk) begin
		match_beat_t got;
		match_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tag   = m_tdata[15:0];
			got.idx   = m_tdata[21:16];
			got.key   = m_tdata[43:22];
			got.mass  = m_tdata[71:44];
			got.inten = m_tdata[103:72];
			got.last  = m_tlast;
			matches_checked++;
			if (pending_matches.size() == 0) begin
				want = '0;
				report_fault("unexpected match beat", want, got);
			end else begin
				want = pending_matches.pop_front();
				if (got !== want)
					report_fault("match beat mismatch", want, got);
			end
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d matches outstanding",
					idle_cycles, pending_matches.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rounding_edges();
		test_pair_modes();
		test_table_full();
		test_output_stall();
		test_random_traffic();
		drain_block();

		$display("summary: %0d items accepted, %0d match beats checked, %0d mismatches",
			items_accepted, matches_checked, mismatches);
		$display("summary: pair modes seen %b, full table, long output stall, random mix",
			modes_seen);
		if (mismatches == 0 && pending_matches.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
